[rtl/core/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// Texture slot cache package
// Shared constants, result codes and control structs for the slot cache core.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

   // Defaults for the top-level parameters.
   localparam int SLOTS_DEFAULT   = 256;
   localparam int MAX_DIM_DEFAULT = 128;

   // Fixed field widths.
   localparam int KEY_W      = 32;
   localparam int STAMP_W    = 32;
   localparam int DIM_IN_W   = 8;
   localparam int SLOT_OUT_W = 8;
   localparam int CFG_W      = 9;

   // Slot count register value after reset.
   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

   // Stamps at or above this bound never make a slot the victim.
   localparam logic [STAMP_W-1:0] STAMP_BOUND = 32'd999999999;

   // Result codes.
   typedef enum logic [2:0] {
      OUT_HIT     = 3'd0,
      OUT_FRESH   = 3'd1,
      OUT_REALLOC = 3'd2,
      OUT_REUSE   = 3'd3,
      OUT_FLUSHED = 3'd4
   } outcome_type;

   // Control bits of the scan packet that walks the cell row.
   typedef struct packed {
      logic valid;
      logic found;
      logic v_alloc;
   } pkt_ctrl_type;

   // Controls broadcast from the top level to every cell.
   typedef struct packed {
      logic flush;
      logic write;
   } bcast_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/texture_slot_cache_unit.sv]
// ----------------------------------------------------------------------------
// Texture slot cache unit
// Fully associative slot cache with oldest-load replacement over a cell row.
// ----------------------------------------------------------------------------
// A scan packet enters the first cell in the accepting cycle and moves one cell
// per cycle down the row of SLOTS cells into an exit register. A finish cycle
// then writes the victim and loads the result register. A new item is accepted
// in the cycle after the finish cycle, even while that result still waits to be
// taken. A held result delays the finish of the next item. Configuration writes
// are taken while no item is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_slot_cache_unit #(
   parameter int SLOTS   = tsc_pkg::SLOTS_DEFAULT,
   parameter int MAX_DIM = tsc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_mode,
   input  wire logic [tsc_pkg::KEY_W-1:0]         req_texture_key,
   input  wire logic [tsc_pkg::DIM_IN_W-1:0]      req_tex_width,
   input  wire logic [tsc_pkg::DIM_IN_W-1:0]      req_tex_height,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [tsc_pkg::SLOT_OUT_W-1:0]         rsp_slot_index,
   output logic [2:0]                             rsp_outcome,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tsc_pkg::CFG_W-1:0]         csr_active_slots
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int N_W   = $clog2(SLOTS+1);
   localparam int DIM_W = $clog2(MAX_DIM+1);
   localparam int CW    = (DIM_W > tsc_pkg::DIM_IN_W) ? DIM_W : tsc_pkg::DIM_IN_W;
   localparam int NX_W  = (N_W > tsc_pkg::CFG_W) ? N_W : tsc_pkg::CFG_W;

   logic [tsc_pkg::CFG_W-1:0]   cfg_ff;
   logic [tsc_pkg::KEY_W-1:0]   key_ff;
   logic                        flush_ff;
   logic [DIM_W-1:0]            w_ff, h_ff;
   logic                        busy_ff;
   logic                        pend_ff;
   logic                        fin_found_ff;
   logic                        fin_alloc_ff;
   logic [IDX_W-1:0]            fin_idx_ff;
   logic [DIM_W-1:0]            fin_w_ff, fin_h_ff;
   logic [tsc_pkg::STAMP_W-1:0] load_counter_ff;
   logic                        rsp_valid_ff;
   logic [tsc_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   tsc_pkg::outcome_type        rsp_outcome_ff;

   logic                        accept;
   logic                        finish;
   logic [N_W-1:0]              n_active;
   logic [NX_W-1:0]             n_ext;
   logic [CW-1:0]               w_ext, h_ext;
   logic [DIM_W-1:0]            w_clamp, h_clamp;
   tsc_pkg::outcome_type        outcome;
   logic [IDX_W-1:0]            res_idx;
   tsc_pkg::bcast_ctrl_type     bc;

   // Scan packet stages: stage k feeds cell k, stage SLOTS leaves the row.
   tsc_pkg::pkt_ctrl_type       st_ctrl [SLOTS+1];
   logic [IDX_W-1:0]            st_idx  [SLOTS+1];
   logic [tsc_pkg::STAMP_W-1:0] st_best [SLOTS+1];
   logic [DIM_W-1:0]            st_w    [SLOTS+1];
   logic [DIM_W-1:0]            st_h    [SLOTS+1];
   logic [SLOTS:0]              st_valid_vec;

   assign accept    = req_valid && !busy_ff;
   assign req_stall = busy_ff;
   assign csr_ready = !busy_ff;
   assign finish    = pend_ff && (!rsp_valid_ff || !rsp_stall);

   // Effective slot count, held to the range one to SLOTS.
   always_comb begin
      n_ext = NX_W'(cfg_ff);
      if (n_ext == '0) begin
         n_ext = NX_W'(1);
      end
      if (n_ext > NX_W'(SLOTS)) begin
         n_ext = NX_W'(SLOTS);
      end
      n_active = N_W'(n_ext);
   end

   // Requested size, held to the range one to MAX_DIM.
   always_comb begin
      w_ext = CW'(req_tex_width);
      h_ext = CW'(req_tex_height);
      if (w_ext == '0) begin
         w_ext = CW'(1);
      end
      if (w_ext > CW'(MAX_DIM)) begin
         w_ext = CW'(MAX_DIM);
      end
      if (h_ext == '0) begin
         h_ext = CW'(1);
      end
      if (h_ext > CW'(MAX_DIM)) begin
         h_ext = CW'(MAX_DIM);
      end
      w_clamp = DIM_W'(w_ext);
      h_clamp = DIM_W'(h_ext);
   end

   // A fresh packet enters the first cell on acceptance.
   always_comb begin
      st_ctrl[0].valid   = accept;
      st_ctrl[0].found   = 1'b0;
      st_ctrl[0].v_alloc = 1'b0;
      st_idx[0]          = '0;
      st_best[0]         = tsc_pkg::STAMP_BOUND;
      st_w[0]            = '0;
      st_h[0]            = '0;
   end

   // Broadcast controls: the flush flag during the scan, the victim write at finish.
   // In the accepting cycle the flag comes from the new item, not the last one.
   always_comb begin
      bc.flush = accept ? req_mode : flush_ff;
      bc.write = finish && !flush_ff && !fin_found_ff;
   end

   // Row of slot cells.
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      tsc_cell #(
         .SLOTS   (SLOTS),
         .MAX_DIM (MAX_DIM),
         .IDX     (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .n_active  (n_active),
         .bc        (bc),
         .req_key   (accept ? req_texture_key : key_ff),
         .upd_idx   (fin_idx_ff),
         .upd_w     (w_ff),
         .upd_h     (h_ff),
         .upd_stamp (load_counter_ff),
         .in_ctrl   (st_ctrl[g]),
         .in_idx    (st_idx[g]),
         .in_best   (st_best[g]),
         .in_w      (st_w[g]),
         .in_h      (st_h[g]),
         .out_ctrl  (st_ctrl[g+1]),
         .out_idx   (st_idx[g+1]),
         .out_best  (st_best[g+1]),
         .out_w     (st_w[g+1]),
         .out_h     (st_h[g+1])
      );
   end

   for (genvar g = 0; g <= SLOTS; g++) begin : g_vld
      assign st_valid_vec[g] = st_ctrl[g].valid;
   end

   // Request registers and item progress flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         cfg_ff  <= tsc_pkg::CFG_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_active_slots;
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (st_ctrl[SLOTS].valid) begin
            pend_ff <= 1'b1;
         end else if (finish) begin
            pend_ff <= 1'b0;
         end
      end
      if (accept) begin
         key_ff   <= req_texture_key;
         flush_ff <= req_mode;
         w_ff     <= w_clamp;
         h_ff     <= h_clamp;
      end
      if (st_ctrl[SLOTS].valid) begin
         fin_found_ff <= st_ctrl[SLOTS].found;
         fin_alloc_ff <= st_ctrl[SLOTS].v_alloc;
         fin_idx_ff   <= st_idx[SLOTS];
         fin_w_ff     <= st_w[SLOTS];
         fin_h_ff     <= st_h[SLOTS];
      end
   end

   // Result code from the scan outcome and the victim's stored size.
   always_comb begin
      res_idx = fin_idx_ff;
      if (flush_ff) begin
         outcome = tsc_pkg::OUT_FLUSHED;
         res_idx = '0;
      end else if (fin_found_ff) begin
         outcome = tsc_pkg::OUT_HIT;
      end else if (!fin_alloc_ff) begin
         outcome = tsc_pkg::OUT_FRESH;
      end else if ((fin_w_ff != w_ff) || (fin_h_ff != h_ff)) begin
         outcome = tsc_pkg::OUT_REALLOC;
      end else begin
         outcome = tsc_pkg::OUT_REUSE;
      end
   end

   // Load counter advances on each victim write and stops at its maximum.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_counter_ff <= '0;
      end else if (bc.write && (load_counter_ff != '1)) begin
         load_counter_ff <= load_counter_ff + tsc_pkg::STAMP_W'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish) begin
         rsp_slot_ff    <= tsc_pkg::SLOT_OUT_W'(res_idx);
         rsp_outcome_ff <= outcome;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_outcome    = rsp_outcome_ff;

   // At most one scan packet is in the row at any time.
   a_one_packet: assert property (@(posedge clock) disable iff (reset)
      $onehot0(st_valid_vec))
      else $error("more than one scan packet in the cell row");

   // An accepted item keeps the unit busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("unit not busy after accepting an item");

   // A packet leaves the row only for an item in progress that is not yet finishing.
   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      st_ctrl[SLOTS].valid |-> (busy_ff && !pend_ff))
      else $error("scan packet left the row with no item in progress");

   // A victim write happens only at the finish of a missed lookup.
   a_write_pend: assert property (@(posedge clock) disable iff (reset)
      bc.write |-> (pend_ff && !flush_ff && !fin_found_ff))
      else $error("victim write outside the finish of a miss");

endmodule

`default_nettype wire

[rtl/core/tsc_cell.sv]
// ----------------------------------------------------------------------------
// Texture slot cache cell
// Holds one slot and forwards the scan packet to the next cell each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_cell #(
   parameter int SLOTS   = tsc_pkg::SLOTS_DEFAULT,
   parameter int MAX_DIM = tsc_pkg::MAX_DIM_DEFAULT,
   parameter int IDX     = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [$clog2(SLOTS+1)-1:0]   n_active,
   input  wire tsc_pkg::bcast_ctrl_type      bc,
   input  wire logic [tsc_pkg::KEY_W-1:0]    req_key,
   input  wire logic [$clog2(SLOTS)-1:0]     upd_idx,
   input  wire logic [$clog2(MAX_DIM+1)-1:0] upd_w,
   input  wire logic [$clog2(MAX_DIM+1)-1:0] upd_h,
   input  wire logic [tsc_pkg::STAMP_W-1:0]  upd_stamp,
   input  wire tsc_pkg::pkt_ctrl_type        in_ctrl,
   input  wire logic [$clog2(SLOTS)-1:0]     in_idx,
   input  wire logic [tsc_pkg::STAMP_W-1:0]  in_best,
   input  wire logic [$clog2(MAX_DIM+1)-1:0] in_w,
   input  wire logic [$clog2(MAX_DIM+1)-1:0] in_h,
   output tsc_pkg::pkt_ctrl_type             out_ctrl,
   output logic [$clog2(SLOTS)-1:0]          out_idx,
   output logic [tsc_pkg::STAMP_W-1:0]       out_best,
   output logic [$clog2(MAX_DIM+1)-1:0]      out_w,
   output logic [$clog2(MAX_DIM+1)-1:0]      out_h
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int N_W   = $clog2(SLOTS+1);
   localparam int DIM_W = $clog2(MAX_DIM+1);
   localparam bit IS_HEAD = (IDX == 0);

   // Slot contents.
   logic [tsc_pkg::KEY_W-1:0]   key_ff;
   logic                        key_valid_ff;
   logic                        alloc_ff;
   logic [DIM_W-1:0]            width_ff;
   logic [DIM_W-1:0]            height_ff;
   logic [tsc_pkg::STAMP_W-1:0] stamp_ff;

   // Outgoing scan packet.
   tsc_pkg::pkt_ctrl_type       ctrl_ff, ctrl_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [tsc_pkg::STAMP_W-1:0] best_ff, best_in;
   logic [DIM_W-1:0]            w_ff, w_in;
   logic [DIM_W-1:0]            h_ff, h_in;

   logic active;
   logic lookup;
   logic hit;
   logic take;
   logic load_info;
   logic do_flush;
   logic do_write;

   // Slot qualifiers for the packet passing through this cycle.
   always_comb begin
      active    = (N_W'(IDX) < n_active);
      lookup    = in_ctrl.valid && !bc.flush && !in_ctrl.found && active;
      hit       = lookup && key_valid_ff && (key_ff == req_key);
      take      = lookup && !hit && (stamp_ff < in_best);
      load_info = take || (IS_HEAD && lookup);
      do_flush  = in_ctrl.valid && bc.flush && active;
      do_write  = bc.write && (upd_idx == IDX_W'(IDX));
   end

   // Next packet: note a hit, or take over as the oldest slot so far.
   always_comb begin
      ctrl_in.valid   = in_ctrl.valid;
      ctrl_in.found   = in_ctrl.found || hit;
      ctrl_in.v_alloc = load_info ? alloc_ff : in_ctrl.v_alloc;
      idx_in          = (hit || take) ? IDX_W'(IDX) : in_idx;
      best_in         = take ? stamp_ff : in_best;
      w_in            = load_info ? width_ff : in_w;
      h_in            = load_info ? height_ff : in_h;
   end

   // Packet register toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
      idx_ff  <= idx_in;
      best_ff <= best_in;
      w_ff    <= w_in;
      h_ff    <= h_in;
   end

   // Slot state: a flush clears the flags, a victim write loads the slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= 1'b0;
         alloc_ff     <= 1'b0;
         stamp_ff     <= '0;
      end else if (do_flush) begin
         key_valid_ff <= 1'b0;
         alloc_ff     <= 1'b0;
      end else if (do_write) begin
         key_valid_ff <= 1'b1;
         alloc_ff     <= 1'b1;
         stamp_ff     <= upd_stamp;
      end
      if (do_write) begin
         key_ff    <= req_key;
         width_ff  <= upd_w;
         height_ff <= upd_h;
      end
   end

   assign out_ctrl = ctrl_ff;
   assign out_idx  = idx_ff;
   assign out_best = best_ff;
   assign out_w    = w_ff;
   assign out_h    = h_ff;

endmodule

`default_nettype wire

[sim/texture_slot_cache_checker.sv]
// ----------------------------------------------------------------------------
// Texture slot cache checker
// Watches the lookup, result and slot count channels of the slot cache. It
// keeps its own copy of the slot table to predict where each accepted item
// lands, and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module texture_slot_cache_checker #(
   parameter int SLOTS   = tsc_pkg::SLOTS_DEFAULT,
   parameter int MAX_DIM = tsc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic                          req_mode,
   input  wire logic [tsc_pkg::KEY_W-1:0]     req_texture_key,
   input  wire logic [tsc_pkg::DIM_IN_W-1:0]  req_tex_width,
   input  wire logic [tsc_pkg::DIM_IN_W-1:0]  req_tex_height,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [tsc_pkg::SLOT_OUT_W-1:0] rsp_slot_index,
   input  wire logic [2:0]                    rsp_outcome,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [tsc_pkg::CFG_W-1:0]     csr_active_slots,
   output int                                 failures,
   output int                                 outstanding
);

   // Where one item is expected to land.
   typedef struct packed {
      logic [tsc_pkg::SLOT_OUT_W-1:0] slot;
      tsc_pkg::outcome_type           outcome;
   } placement_type;

   // Shadow slot table.
   logic [tsc_pkg::KEY_W-1:0]   slot_tag    [SLOTS];
   logic                        tag_live    [SLOTS];
   logic                        slot_backed [SLOTS];
   int unsigned                 slot_w      [SLOTS];
   int unsigned                 slot_h      [SLOTS];
   logic [tsc_pkg::STAMP_W-1:0] slot_age    [SLOTS];
   logic [tsc_pkg::STAMP_W-1:0] load_count;
   logic [tsc_pkg::CFG_W-1:0]   slots_cfg;

   placement_type expected_placements[$];

   // Register value mapped onto the slots that actually take part.
   function automatic int unsigned slots_in_use();
      int unsigned n;
      n = slots_cfg;
      if (n < 1) n = 1;
      if (n > SLOTS) n = SLOTS;
      return n;
   endfunction

   // Requested dimensions are pulled into 1..MAX_DIM.
   function automatic int unsigned clamp_dim(input logic [tsc_pkg::DIM_IN_W-1:0] v);
      int unsigned d;
      d = v;
      if (d < 1) d = 1;
      if (d > MAX_DIM) d = MAX_DIM;
      return d;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t texture_slot_cache_checker: %s", $time, msg);
      failures++;
   endtask

   task automatic reset_cache();
      for (int i = 0; i < SLOTS; i++) begin
         slot_tag[i]    = '0;
         tag_live[i]    = 1'b0;
         slot_backed[i] = 1'b0;
         slot_w[i]      = 0;
         slot_h[i]      = 0;
         slot_age[i]    = '0;
      end
      load_count = '0;
      slots_cfg  = tsc_pkg::CFG_RESET;
      expected_placements.delete();
   endtask

   // Apply one accepted item to the shadow table and queue its placement.
   task automatic predict_placement(input logic mode,
                                    input logic [tsc_pkg::KEY_W-1:0] key,
                                    input logic [tsc_pkg::DIM_IN_W-1:0] w_in,
                                    input logic [tsc_pkg::DIM_IN_W-1:0] h_in);
      placement_type               want;
      int unsigned                 n;
      int unsigned                 w;
      int unsigned                 h;
      int unsigned                 victim;
      int unsigned                 hit_slot;
      logic                        hit;
      logic [tsc_pkg::STAMP_W-1:0] best;
      n = slots_in_use();
      if (mode) begin
         // A flush empties the active slots only and keeps every stamp.
         for (int i = 0; i < n; i++) begin
            tag_live[i]    = 1'b0;
            slot_backed[i] = 1'b0;
         end
         want.slot    = '0;
         want.outcome = tsc_pkg::OUT_FLUSHED;
      end else begin
         w        = clamp_dim(w_in);
         h        = clamp_dim(h_in);
         best     = tsc_pkg::STAMP_BOUND;
         victim   = 0;
         hit_slot = 0;
         hit      = 1'b0;
         // First live match wins; otherwise track the first oldest stamp.
         for (int i = 0; i < n; i++) begin
            if (!hit) begin
               if (tag_live[i] && slot_tag[i] == key) begin
                  hit      = 1'b1;
                  hit_slot = i;
               end else if (slot_age[i] < best) begin
                  best   = slot_age[i];
                  victim = i;
               end
            end
         end
         if (hit) begin
            want.slot    = hit_slot[tsc_pkg::SLOT_OUT_W-1:0];
            want.outcome = tsc_pkg::OUT_HIT;
         end else begin
            if (!slot_backed[victim]) begin
               want.outcome = tsc_pkg::OUT_FRESH;
            end else if (slot_w[victim] != w || slot_h[victim] != h) begin
               want.outcome = tsc_pkg::OUT_REALLOC;
            end else begin
               want.outcome = tsc_pkg::OUT_REUSE;
            end
            slot_backed[victim] = 1'b1;
            slot_w[victim]      = w;
            slot_h[victim]      = h;
            slot_tag[victim]    = key;
            tag_live[victim]    = 1'b1;
            slot_age[victim]    = load_count;
            // The load counter sticks at its maximum.
            if (load_count != '1) load_count++;
            want.slot = victim[tsc_pkg::SLOT_OUT_W-1:0];
         end
      end
      expected_placements.push_back(want);
   endtask

   // Compare one accepted result with the oldest prediction.
   task automatic check_placement();
      placement_type want;
      if (expected_placements.size() == 0) begin
         report_mismatch($sformatf("result with nothing pending: slot %0d outcome %0d",
                                   rsp_slot_index, rsp_outcome));
      end else begin
         want = expected_placements.pop_front();
         if (rsp_slot_index !== want.slot) begin
            report_mismatch($sformatf("slot_index got %0d expected %0d",
                                      rsp_slot_index, want.slot));
         end
         if (rsp_outcome !== want.outcome) begin
            report_mismatch($sformatf("outcome got %0d expected %0d (%s)",
                                      rsp_outcome, want.outcome, want.outcome.name()));
         end
      end
   endtask

   // Sample all three channels at the clock edge.
   always @(posedge clock) begin
      if (reset) begin
         reset_cache();
         failures    = 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) slots_cfg = csr_active_slots;
         if (rsp_valid && !rsp_stall) check_placement();
         if (req_valid && !req_stall) begin
            predict_placement(req_mode, req_texture_key, req_tex_width, req_tex_height);
         end
         outstanding <= expected_placements.size();
      end
   end

endmodule

[sim/tb_texture_slot_cache_unit.sv]
// ----------------------------------------------------------------------------
// Texture slot cache unit testbench
// Drives directed and random lookup and flush items through the slot cache
// under several slot counts, with random idle bursts on both channels and one
// long result hold-off. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------

module tb_texture_slot_cache_unit;

   localparam int HOLD_CYCLES  = 1500;
   localparam int DRAIN_CYCLES = 300;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 83;
   localparam int RUN_LIMIT    = 12000000;

   logic                               clock            = 1'b0;
   logic                               reset            = 1'b1;
   logic                               req_valid        = 1'b0;
   logic                               req_mode         = 1'b0;
   logic [tsc_pkg::KEY_W-1:0]          req_texture_key  = '0;
   logic [tsc_pkg::DIM_IN_W-1:0]       req_tex_width    = 8'd1;
   logic [tsc_pkg::DIM_IN_W-1:0]       req_tex_height   = 8'd1;
   logic                               rsp_stall        = 1'b0;
   logic                               csr_valid        = 1'b0;
   logic [tsc_pkg::CFG_W-1:0]          csr_active_slots = tsc_pkg::CFG_RESET;
   wire logic                          req_stall;
   wire logic                          rsp_valid;
   wire logic                          csr_ready;
   wire logic [tsc_pkg::SLOT_OUT_W-1:0] rsp_slot_index;
   wire logic [2:0]                    rsp_outcome;
   int                                 failures;
   int                                 outstanding;

   // Idle control for the sender and the receiver; quiet is shared by both.
   logic                  quiet      = 1'b0;
   logic                  hold_start = 1'b0;
   int unsigned           stall_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   texture_slot_cache_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_texture_key  (req_texture_key),
      .req_tex_width    (req_tex_width),
      .req_tex_height   (req_tex_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_outcome      (rsp_outcome),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_slots (csr_active_slots)
   );

   texture_slot_cache_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_texture_key  (req_texture_key),
      .req_tex_width    (req_tex_width),
      .req_tex_height   (req_tex_height),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_outcome      (rsp_outcome),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_active_slots (csr_active_slots),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 17);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(RUN_LIMIT);
      $display("tb_texture_slot_cache_unit: FAIL");
      $finish;
   end

   // Offer one item, hold it until taken, then maybe idle for a burst.
   task automatic offer_item(input logic mode, input logic [tsc_pkg::KEY_W-1:0] key,
                             input logic [tsc_pkg::DIM_IN_W-1:0] w,
                             input logic [tsc_pkg::DIM_IN_W-1:0] h);
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_texture_key <= key;
      req_tex_width   <= w;
      req_tex_height  <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [tsc_pkg::CFG_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_active_slots <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly two common sizes so victims get reused, sometimes anything.
   function automatic logic [tsc_pkg::DIM_IN_W-1:0] pick_dim();
      int unsigned sel;
      sel = $urandom_range(0, 5);
      if (sel == 0) return tsc_pkg::DIM_IN_W'($urandom_range(0, 255));
      else if (sel < 4) return 8'd16;
      else return 8'd32;
   endfunction

   // Keys come mostly from a small pool so that hits and evictions mix.
   task automatic offer_random_item(input logic [tsc_pkg::KEY_W-1:0] pool_base,
                                    input int unsigned pool_size);
      logic [tsc_pkg::KEY_W-1:0] key;
      if ($urandom_range(0, 19) == 0) begin
         offer_item(1'b1, $urandom, pick_dim(), pick_dim());
      end else begin
         if ($urandom_range(0, 7) == 0) key = $urandom;
         else key = pool_base + $urandom_range(0, pool_size - 1);
         offer_item(1'b0, key, pick_dim(), pick_dim());
      end
   endtask

   // Main sequence: reset, directed items, then random phases.
   initial begin
      int unsigned               phase_slots[PHASES];
      int unsigned               eff;
      int unsigned               pool;
      logic [tsc_pkg::KEY_W-1:0] pool_base;
      phase_slots    = '{3, 1, 8, 2, 256, 0, 300, 5, 20, 4};
      phase_slots[8] = $urandom_range(6, 40);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full cache after reset: fresh slots, hits, clamped sizes, a flush.
      offer_item(1'b0, 32'h0000_0000, 8'd1, 8'd1);
      offer_item(1'b0, 32'h0000_0000, 8'd1, 8'd1);
      offer_item(1'b0, 32'hFFFF_FFFF, 8'd128, 8'd128);
      offer_item(1'b0, 32'h1234_5678, 8'd0, 8'd0);
      offer_item(1'b0, 32'h1234_5678, 8'd255, 8'd200);
      offer_item(1'b0, 32'hA5A5_A5A5, 8'd255, 8'd129);
      offer_item(1'b1, 32'hFFFF_FFFF, 8'd255, 8'd255);
      offer_item(1'b0, 32'h0000_0000, 8'd1, 8'd1);

      // Two slots: reallocation after a size change and reuse at same size.
      drain_results();
      write_slot_count(9'd2);
      offer_item(1'b0, 32'h0000_0100, 8'd16, 8'd16);
      offer_item(1'b0, 32'h0000_0101, 8'd16, 8'd16);
      offer_item(1'b0, 32'h0000_0102, 8'd16, 8'd16);
      offer_item(1'b0, 32'hA5A5_A5A5, 8'd128, 8'd128);

      // A count of zero acts as one slot; the flush then spares slot one.
      drain_results();
      write_slot_count(9'd0);
      offer_item(1'b0, 32'h0000_0200, 8'd8, 8'd8);
      offer_item(1'b0, 32'h0000_0201, 8'd8, 8'd8);
      offer_item(1'b0, 32'h0000_0201, 8'd8, 8'd8);
      offer_item(1'b1, 32'h5A5A_5A5A, 8'd0, 8'd0);

      // Count above the slot total acts as all slots.
      drain_results();
      write_slot_count(9'd511);
      offer_item(1'b0, 32'h0000_0102, 8'd16, 8'd16);
      offer_item(1'b0, 32'h0000_0201, 8'd8, 8'd8);
      offer_item(1'b0, 32'h8000_0300, 8'd128, 8'd1);
      offer_item(1'b0, 32'h7FFF_FFFF, 8'd1, 8'd128);

      // Random phases, each under its own slot count.
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         write_slot_count(phase_slots[p][tsc_pkg::CFG_W-1:0]);
         eff = phase_slots[p][tsc_pkg::CFG_W-1:0];
         if (eff == 0) eff = 1;
         if (eff > tsc_pkg::SLOTS_DEFAULT) eff = tsc_pkg::SLOTS_DEFAULT;
         pool      = (2 * eff + 2 > 64) ? 64 : 2 * eff + 2;
         pool_base = $urandom;
         if (p == 2) hold_start = 1'b1;
         if (p == PHASES - 1) quiet = 1'b1;
         repeat (PHASE_ITEMS) offer_random_item(pool_base, pool);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb_texture_slot_cache_unit: PASS");
      end else begin
         $display("tb_texture_slot_cache_unit: FAIL");
      end
      $finish;
   end

endmodule
